// ===== hdl/sdspi_pkg.sv =====
package sdspi_pkg;

	typedef enum logic [4:0] {
		PH_IDLE, PH_WAKE, PH_FRAME, PH_RESP, PH_RECV, PH_TOKEN, PH_RDATA,
		PH_WGAP, PH_WTOKEN, PH_WREQ, PH_WDATA, PH_WCRC, PH_WRESP, PH_WBUSY,
		PH_STOPTOK, PH_STOPGAP, PH_BUSY, PH_RELEASE
	} phase_t;

	localparam logic [2:0] OP_INIT  = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_XDONE = 3'd3;
	localparam logic [2:0] OP_WDATA = 3'd4;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOCARD = 3'd1;
	localparam logic [2:0] ST_NOINIT = 3'd2;
	localparam logic [2:0] ST_PARAM  = 3'd3;
	localparam logic [2:0] ST_WREJ   = 3'd4;

	localparam logic [1:0] CFG_TRIES = 2'd0;
	localparam logic [1:0] CFG_WAKE  = 2'd1;
	localparam logic [1:0] CFG_MAXB  = 2'd2;

	localparam logic [5:0] CMD_GO    = 6'd0;
	localparam logic [5:0] CMD_IFC   = 6'd8;
	localparam logic [5:0] CMD_STOP  = 6'd12;
	localparam logic [5:0] CMD_BLEN  = 6'd16;
	localparam logic [5:0] CMD_RD1   = 6'd17;
	localparam logic [5:0] CMD_RDM   = 6'd18;
	localparam logic [5:0] CMD_WR1   = 6'd24;
	localparam logic [5:0] CMD_WRM   = 6'd25;
	localparam logic [5:0] CMD_OPC   = 6'd41;
	localparam logic [5:0] CMD_APP   = 6'd55;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       select_low;
		logic       fast_clock;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       data_request;
		logic       done_res;
		logic [2:0] status;
	} result_t;

endpackage

// ===== hdl/sd_card_spi_host_sequencer_unit.sv =====
// SD card SPI-mode host sequencer. Each accepted request is one host request
// (init, read, write), one completed link byte exchange, or one write data byte;
// it yields at most one result in the next cycle, and a new request can be taken
// every cycle unless a stalled result waits: the next-byte decision is a single
// pass of logic from the state registers to the result register, with the result
// register as the only buffer. Items that mean nothing in this phase yield no result.
module sd_card_spi_host_sequencer_unit
	import sdspi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic        card_present,
	input  logic [22:0] sector,
	input  logic [7:0]  block_count,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        select_low,
	output logic        fast_clock,
	output logic        read_valid,
	output logic [7:0]  read_byte,
	output logic        data_request,
	output logic        done_res,
	output logic [2:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	logic [7:0] tries_q, wake_q, maxb_q;
	logic       go, emit;
	result_t    res, res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tries_q <= 8'd8;
			wake_q  <= 8'd10;
			maxb_q  <= 8'd128;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRIES: tries_q <= cfg_data;
				CFG_WAKE:  wake_q  <= cfg_data;
				CFG_MAXB:  maxb_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// stall only while a result waits and cannot leave
	assign in_stall = out_valid && out_stall;
	assign go = in_valid && !in_stall;

	sdspi_seq u_seq (
		.clk, .arst_n, .go, .opcode, .card_present, .sector, .block_count,
		.rx_byte, .data_byte, .tries_cfg(tries_q), .wake_cfg(wake_q),
		.maxb_cfg(maxb_q), .emit, .res
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (go) out_valid <= emit;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (go && emit) res_q <= res;
	end

	assign tx_valid     = res_q.tx_valid;
	assign tx_byte      = res_q.tx_byte;
	assign select_low   = res_q.select_low;
	assign fast_clock   = res_q.fast_clock;
	assign read_valid   = res_q.read_valid;
	assign read_byte    = res_q.read_byte;
	assign data_request = res_q.data_request;
	assign done_res     = res_q.done_res;
	assign status       = res_q.status;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid) else $error("result lost under stall");
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> !tx_valid && !data_request)
		else $error("byte issued at finish");
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !done_res) |-> status == ST_OK) else $error("stray status");
endmodule

// ===== hdl/sdspi_seq.sv =====
module sdspi_seq
	import sdspi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [2:0]  opcode,
	input  logic        card_present,
	input  logic [22:0] sector,
	input  logic [7:0]  block_count,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  tries_cfg,
	input  logic [7:0]  wake_cfg,
	input  logic [7:0]  maxb_cfg,
	output logic        emit,
	output result_t     res
);
	phase_t      phase_q, ph_n;
	logic [9:0]  idx_q, idx_n;
	logic [7:0]  blk_q, blk_n, tries_q, tries_n;
	logic [31:0] addr_q, addr_n;
	logic [5:0]  cmd_q, cmd_n;
	logic [15:0] echo_q, echo_n;
	logic [1:0]  kind_q, kind_n;
	logic        multi_q, multi_n, fast_q, fast_n;
	logic [7:0]  tries1, wake1;

	assign tries1 = (tries_cfg == 8'd0) ? 8'd1 : tries_cfg;
	assign wake1  = (wake_cfg == 8'd0) ? 8'd1 : wake_cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			blk_q   <= '0;
			tries_q <= '0;
			addr_q  <= '0;
			cmd_q   <= '0;
			echo_q  <= '0;
			kind_q  <= '0;
			multi_q <= 1'b0;
			fast_q  <= 1'b0;
		end else if (go) begin
			phase_q <= ph_n;
			idx_q   <= idx_n;
			blk_q   <= blk_n;
			tries_q <= tries_n;
			addr_q  <= addr_n;
			cmd_q   <= cmd_n;
			echo_q  <= echo_n;
			kind_q  <= kind_n;
			multi_q <= multi_n;
			fast_q  <= fast_n;
		end
	end

	always_comb begin
		logic       do_start, do_fin, do_issue, hit, bnd, want_ok;
		phase_t     sph;
		logic [2:0] st;
		logic [7:0] b, blkd;
		ph_n = phase_q; idx_n = idx_q; blk_n = blk_q; tries_n = tries_q;
		addr_n = addr_q; cmd_n = cmd_q; echo_n = echo_q; kind_n = kind_q;
		multi_n = multi_q; fast_n = fast_q;
		do_start = 1'b0; do_fin = 1'b0; do_issue = 1'b0; sph = PH_IDLE;
		st = ST_OK; emit = 1'b0; hit = 1'b0; b = 8'hFF;
		res = '0;
		bnd = (cmd_q == CMD_GO) || (cmd_q == CMD_IFC) || (cmd_q == CMD_APP) ||
			(cmd_q == CMD_OPC) || (cmd_q == CMD_BLEN);
		want_ok = (cmd_q == CMD_GO || cmd_q == CMD_IFC) ? (rx_byte == 8'h01)
			: (rx_byte == 8'h00);
		blkd = (blk_q != 8'd0) ? blk_q - 8'd1 : blk_q;

		if (opcode == OP_INIT || opcode == OP_READ || opcode == OP_WRITE) begin
			if (phase_q == PH_IDLE) begin
				emit = 1'b1;
				kind_n = opcode[1:0];
				if (opcode == OP_INIT) begin
					fast_n = 1'b0; multi_n = 1'b0; echo_n = '0;
					if (!card_present) begin
						do_fin = 1'b1; st = ST_NOCARD;
					end else begin
						do_start = 1'b1; sph = PH_WAKE;
					end
				end else if (block_count > maxb_cfg) begin
					do_fin = 1'b1; st = ST_PARAM;
				end else begin
					multi_n = block_count > 8'd1;
					blk_n = (block_count != 8'd0) ? block_count : 8'd1;
					if (opcode == OP_READ)
						cmd_n = (block_count > 8'd1) ? CMD_RDM : CMD_RD1;
					else
						cmd_n = (block_count > 8'd1) ? CMD_WRM : CMD_WR1;
					addr_n = {sector, 9'd0};
					do_start = 1'b1; sph = PH_FRAME;
				end
			end
		end else if (opcode == OP_XDONE) begin
			if (phase_q != PH_IDLE && phase_q != PH_WREQ) begin
				emit = 1'b1;
				case (phase_q)
					PH_WAKE: begin
						idx_n = idx_q + 10'd1;
						if (idx_n >= {2'b0, wake1}) begin
							cmd_n = CMD_GO; addr_n = '0; do_start = 1'b1; sph = PH_FRAME;
						end else do_issue = 1'b1;
					end
					PH_FRAME: begin
						idx_n = idx_q + 10'd1;
						if (idx_n >= 10'd6) begin
							do_start = 1'b1; sph = PH_RESP;
						end else do_issue = 1'b1;
					end
					PH_RESP: begin
						if (want_ok || !bnd || tries_q <= 8'd1) begin
							if (!want_ok && !bnd) do_issue = 1'b1;
							else begin
								hit = want_ok;
								// response handling per command
								case (cmd_q)
									CMD_GO: if (hit) begin
										cmd_n = CMD_IFC; addr_n = 32'h1AA; do_start = 1'b1; sph = PH_FRAME;
									end else begin
										do_fin = 1'b1; st = ST_NOINIT;
									end
									CMD_IFC: if (hit) begin
										do_start = 1'b1; sph = PH_RECV;
									end else begin
										multi_n = 1'b0; cmd_n = CMD_APP; addr_n = '0;
										do_start = 1'b1; sph = PH_FRAME;
									end
									CMD_APP: begin
										cmd_n = CMD_OPC; addr_n = multi_q ? 32'h4000_0000 : 32'h0;
										do_start = 1'b1; sph = PH_FRAME;
									end
									CMD_OPC: if (!multi_q) begin
										cmd_n = CMD_BLEN; addr_n = 32'd512; do_start = 1'b1; sph = PH_FRAME;
									end else if (hit) begin
										do_start = 1'b1; sph = PH_RECV;
									end else begin
										cmd_n = CMD_APP; addr_n = '0; do_start = 1'b1; sph = PH_FRAME;
									end
									CMD_BLEN: begin
										do_start = 1'b1;
										if (hit) sph = PH_RELEASE;
										else begin
											addr_n = 32'd512; sph = PH_FRAME;
										end
									end
									CMD_STOP: begin
										do_start = 1'b1; sph = PH_BUSY;
									end
									default: begin
										do_start = 1'b1; sph = (kind_q == 2'd1) ? PH_TOKEN : PH_WGAP;
									end
								endcase
							end
						end else begin
							tries_n = tries_q - 8'd1; do_issue = 1'b1;
						end
					end
					PH_RECV: begin
						idx_n = idx_q + 10'd1;
						if (cmd_q == CMD_IFC) begin
							if (idx_q == 10'd2) echo_n[15:8] = rx_byte;
							if (idx_q == 10'd3) echo_n[7:0] = rx_byte;
							if (idx_n < 10'd4) do_issue = 1'b1;
							else if (echo_n == 16'h01AA) begin
								multi_n = 1'b1; cmd_n = CMD_APP; addr_n = '0;
								do_start = 1'b1; sph = PH_FRAME;
							end else begin
								do_fin = 1'b1; st = ST_NOINIT;
							end
						end else if (idx_n < 10'd3) do_issue = 1'b1;
						else begin
							cmd_n = CMD_BLEN; addr_n = 32'd512; do_start = 1'b1; sph = PH_FRAME;
						end
					end
					PH_TOKEN: if (rx_byte == 8'hFE) begin
						do_start = 1'b1; sph = PH_RDATA;
					end else do_issue = 1'b1;
					PH_RDATA: begin
						if (idx_q < 10'd512) begin
							res.read_valid = 1'b1; res.read_byte = rx_byte;
						end
						idx_n = idx_q + 10'd1;
						if (idx_n < 10'd514) do_issue = 1'b1;
						else begin
							blk_n = blkd;
							if (blkd != 8'd0) begin
								do_start = 1'b1; sph = PH_TOKEN;
							end else if (multi_q) begin
								cmd_n = CMD_STOP; addr_n = '0; do_start = 1'b1; sph = PH_FRAME;
							end else begin
								do_start = 1'b1; sph = PH_BUSY;
							end
						end
					end
					PH_WGAP: begin
						do_start = 1'b1; sph = PH_WTOKEN;
					end
					PH_WTOKEN: begin
						do_start = 1'b1; sph = PH_WREQ;
					end
					PH_WDATA: begin
						idx_n = idx_q + 10'd1;
						if (idx_q == 10'd511) begin
							do_start = 1'b1; sph = PH_WCRC;
						end else begin
							ph_n = PH_WREQ; do_issue = 1'b1;
						end
					end
					PH_WCRC: begin
						idx_n = idx_q + 10'd1;
						if (idx_n >= 10'd2) begin
							do_start = 1'b1; sph = PH_WRESP;
						end else do_issue = 1'b1;
					end
					PH_WRESP: if (rx_byte[4:0] != 5'h05) begin
						do_fin = 1'b1; st = ST_WREJ;
					end else begin
						do_start = 1'b1; sph = multi_q ? PH_WBUSY : PH_BUSY;
					end
					PH_WBUSY: if (rx_byte == 8'd0) do_issue = 1'b1;
					else begin
						blk_n = blkd; do_start = 1'b1;
						sph = (blkd != 8'd0) ? PH_WTOKEN : PH_STOPTOK;
					end
					PH_STOPTOK: begin
						do_start = 1'b1; sph = PH_STOPGAP;
					end
					PH_STOPGAP: begin
						do_start = 1'b1; sph = PH_BUSY;
					end
					PH_BUSY: if (rx_byte != 8'd0) begin
						do_start = 1'b1; sph = PH_RELEASE;
					end else do_issue = 1'b1;
					PH_RELEASE: begin
						if (kind_q == 2'd0) fast_n = 1'b1;
						do_fin = 1'b1; st = ST_OK;
					end
					default: emit = 1'b0;
				endcase
			end
		end else if (opcode == OP_WDATA) begin
			if (phase_q == PH_WREQ) begin
				emit = 1'b1; ph_n = PH_WDATA;
				res.tx_valid = 1'b1; res.tx_byte = data_byte;
			end
		end

		if (do_start) begin
			ph_n = sph; idx_n = '0; tries_n = tries1; do_issue = 1'b1;
		end
		if (do_issue) begin
			if (ph_n == PH_WREQ) res.data_request = 1'b1;
			else begin
				case (ph_n)
					PH_FRAME: begin
						case (idx_n[2:0])
							3'd0: b = {2'b01, cmd_n};
							3'd1: b = addr_n[31:24];
							3'd2: b = addr_n[23:16];
							3'd3: b = addr_n[15:8];
							3'd4: b = addr_n[7:0];
							default: b = (cmd_n == CMD_GO) ? 8'h95 :
								(cmd_n == CMD_IFC) ? 8'h87 : 8'hFF;
						endcase
					end
					PH_WTOKEN:  b = multi_n ? 8'hFC : 8'hFE;
					PH_STOPTOK: b = 8'hFD;
					default:    b = 8'hFF;
				endcase
				res.tx_valid = 1'b1; res.tx_byte = b;
			end
		end
		if (do_fin) begin
			ph_n = PH_IDLE;
			res.tx_valid = 1'b0; res.tx_byte = '0; res.data_request = 1'b0;
			res.done_res = 1'b1; res.status = st;
		end
		res.select_low = (ph_n != PH_IDLE && ph_n != PH_WAKE && ph_n != PH_RELEASE);
		res.fast_clock = fast_n;
	end
endmodule

// ===== tb/sv/sdspi_checker.sv =====
`timescale 1ns / 100ps

module sdspi_checker
	import sdspi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic        card_present,
	input  logic [22:0] sector,
	input  logic [7:0]  block_count,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        tx_valid,
	input  logic [7:0]  tx_byte,
	input  logic        select_low,
	input  logic        fast_clock,
	input  logic        read_valid,
	input  logic [7:0]  read_byte,
	input  logic        data_request,
	input  logic        done_res,
	input  logic [2:0]  status,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          pending,
	output phase_t      cur_phase,
	output logic [5:0]  cur_cmd,
	output logic [9:0]  cur_idx
);

	// sequencer copy
	logic [7:0]  n_tries, n_wake, n_maxb;
	phase_t      ph;
	logic [9:0]  bidx;
	logic [7:0]  blocks, tries;
	logic [31:0] arg;
	logic [5:0]  cmd;
	logic [15:0] echo;
	logic [1:0]  kind;
	logic        multi, fast;
	result_t     nxt, want, seen;
	result_t     expq[$];
	int          err_cnt;

	assign errors = err_cnt;

	function automatic logic [7:0] frame_byte(int i);
		if (i == 0)
			return 8'h40 | {2'b00, cmd};
		if (i <= 4)
			return 8'(arg >> (8 * (4 - i)));
		if (cmd == CMD_GO)
			return 8'h95;
		if (cmd == CMD_IFC)
			return 8'h87;
		return 8'hFF;
	endfunction

	function void issue();
		logic [7:0] b;
		b = 8'hFF;
		if (ph == PH_WREQ) begin
			nxt.data_request = 1'b1;
			return;
		end
		if (ph == PH_FRAME)
			b = frame_byte(int'(bidx));
		else if (ph == PH_WTOKEN)
			b = multi ? 8'hFC : 8'hFE;
		else if (ph == PH_STOPTOK)
			b = 8'hFD;
		nxt.tx_valid = 1'b1;
		nxt.tx_byte = b;
	endfunction

	function void start(phase_t p);
		ph = p;
		bidx = '0;
		tries = (n_tries != 0) ? n_tries : 8'd1;
		issue();
	endfunction

	function void send_cmd(logic [5:0] c, logic [31:0] a);
		cmd = c;
		arg = a;
		start(PH_FRAME);
	endfunction

	function void finish(logic [2:0] st);
		ph = PH_IDLE;
		nxt.tx_valid = 1'b0;
		nxt.tx_byte = '0;
		nxt.data_request = 1'b0;
		nxt.done_res = 1'b1;
		nxt.status = st;
	endfunction

	function bit bounded();
		return cmd == CMD_GO || cmd == CMD_IFC || cmd == CMD_APP ||
			cmd == CMD_OPC || cmd == CMD_BLEN;
	endfunction

	function void after_response(bit hit);
		case (cmd)
			CMD_GO: begin
				if (hit) send_cmd(CMD_IFC, 32'h1AA);
				else finish(ST_NOINIT);
			end
			CMD_IFC: begin
				if (hit) start(PH_RECV);
				else begin
					multi = 1'b0;
					send_cmd(CMD_APP, '0);
				end
			end
			CMD_APP: send_cmd(CMD_OPC, multi ? 32'h4000_0000 : 32'h0);
			CMD_OPC: begin
				if (!multi) send_cmd(CMD_BLEN, 32'd512);
				else if (hit) start(PH_RECV);
				else send_cmd(CMD_APP, '0);
			end
			CMD_BLEN: begin
				if (hit) start(PH_RELEASE);
				else send_cmd(CMD_BLEN, 32'd512);
			end
			CMD_STOP: start(PH_BUSY);
			default: start((kind == OP_READ[1:0]) ? PH_TOKEN : PH_WGAP);
		endcase
	endfunction

	function void exchanged(logic [7:0] r);
		logic [7:0] hit_byte;
		case (ph)
			PH_WAKE: begin
				bidx++;
				if (bidx >= ((n_wake != 0) ? n_wake : 8'd1)) send_cmd(CMD_GO, '0);
				else issue();
			end
			PH_FRAME: begin
				bidx++;
				if (bidx >= 6) start(PH_RESP);
				else issue();
			end
			PH_RESP: begin
				hit_byte = (cmd == CMD_GO || cmd == CMD_IFC) ? 8'h01 : 8'h00;
				if (r == hit_byte) after_response(1'b1);
				else if (!bounded()) issue();
				else if (tries <= 1) after_response(1'b0);
				else begin
					tries--;
					issue();
				end
			end
			PH_RECV: begin
				if (cmd == CMD_IFC && bidx == 2) echo[15:8] = r;
				if (cmd == CMD_IFC && bidx == 3) echo[7:0] = r;
				bidx++;
				if (cmd == CMD_IFC) begin
					if (bidx < 4) issue();
					else if (echo == 16'h01AA) begin
						multi = 1'b1;
						send_cmd(CMD_APP, '0);
					end else finish(ST_NOINIT);
				end else begin
					if (bidx < 3) issue();
					else send_cmd(CMD_BLEN, 32'd512);
				end
			end
			PH_TOKEN: begin
				if (r == 8'hFE) start(PH_RDATA);
				else issue();
			end
			PH_RDATA: begin
				if (bidx < 512) begin
					nxt.read_valid = 1'b1;
					nxt.read_byte = r;
				end
				bidx++;
				if (bidx < 514) issue();
				else begin
					if (blocks > 0) blocks--;
					if (blocks > 0) start(PH_TOKEN);
					else if (multi) send_cmd(CMD_STOP, '0);
					else start(PH_BUSY);
				end
			end
			PH_WGAP: start(PH_WTOKEN);
			PH_WTOKEN: start(PH_WREQ);
			PH_WDATA: begin
				bidx++;
				if (bidx >= 512) start(PH_WCRC);
				else begin
					ph = PH_WREQ;
					issue();
				end
			end
			PH_WCRC: begin
				bidx++;
				if (bidx >= 2) start(PH_WRESP);
				else issue();
			end
			PH_WRESP: begin
				if ((r & 8'h1F) != 8'h05) finish(ST_WREJ);
				else start(multi ? PH_WBUSY : PH_BUSY);
			end
			PH_WBUSY: begin
				if (r == 0) issue();
				else begin
					if (blocks > 0) blocks--;
					start((blocks > 0) ? PH_WTOKEN : PH_STOPTOK);
				end
			end
			PH_STOPTOK: start(PH_STOPGAP);
			PH_STOPGAP: start(PH_BUSY);
			PH_BUSY: begin
				if (r != 0) start(PH_RELEASE);
				else issue();
			end
			PH_RELEASE: begin
				if (kind == OP_INIT[1:0]) fast = 1'b1;
				finish(ST_OK);
			end
			default: ;
		endcase
	endfunction

	// returns 1 when the request yields a result, left in nxt
	function bit predict(logic [2:0] op, logic cp, logic [22:0] sec, logic [7:0] cnt,
			logic [7:0] rx, logic [7:0] wd);
		nxt = '0;
		if (op == OP_INIT || op == OP_READ || op == OP_WRITE) begin
			if (ph != PH_IDLE) return 1'b0;
			kind = op[1:0];
			if (op == OP_INIT) begin
				fast = 1'b0;
				multi = 1'b0;
				echo = '0;
				if (!cp) finish(ST_NOCARD);
				else start(PH_WAKE);
			end else if (cnt > n_maxb) begin
				finish(ST_PARAM);
			end else begin
				multi = cnt > 1;
				blocks = (cnt != 0) ? cnt : 8'd1;
				if (op == OP_READ) send_cmd(multi ? CMD_RDM : CMD_RD1, {sec, 9'b0});
				else send_cmd(multi ? CMD_WRM : CMD_WR1, {sec, 9'b0});
			end
		end else if (op == OP_XDONE) begin
			if (ph == PH_IDLE || ph == PH_WREQ) return 1'b0;
			exchanged(rx);
		end else if (op == OP_WDATA) begin
			if (ph != PH_WREQ) return 1'b0;
			ph = PH_WDATA;
			nxt.tx_valid = 1'b1;
			nxt.tx_byte = wd;
		end else begin
			return 1'b0;
		end
		nxt.select_low = (ph != PH_IDLE && ph != PH_WAKE && ph != PH_RELEASE);
		nxt.fast_clock = fast;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_tries = 8'd8; n_wake = 8'd10; n_maxb = 8'd128;
			ph = PH_IDLE; bidx = '0; blocks = '0; tries = '0; arg = '0;
			cmd = '0; echo = '0; kind = '0; multi = 1'b0; fast = 1'b0;
			expq.delete();
			err_cnt = 0;
			pending <= 0;
			cur_phase <= PH_IDLE;
			cur_cmd <= '0;
			cur_idx <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TRIES: n_tries = cfg_data;
					CFG_WAKE:  n_wake = cfg_data;
					CFG_MAXB:  n_maxb = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen = {tx_valid, tx_byte, select_low, fast_clock, read_valid, read_byte,
					data_request, done_res, status};
				if (expq.size() == 0) begin
					$error("result with nothing expected");
					err_cnt++;
				end else begin
					want = expq.pop_front();
					if (seen.tx_valid !== want.tx_valid) begin
						$error("tx_valid expected %0h got %0h", want.tx_valid, seen.tx_valid);
						err_cnt++;
					end
					if (seen.tx_byte !== want.tx_byte) begin
						$error("tx_byte expected %0h got %0h", want.tx_byte, seen.tx_byte);
						err_cnt++;
					end
					if (seen.select_low !== want.select_low) begin
						$error("select_low expected %0h got %0h", want.select_low,
							seen.select_low);
						err_cnt++;
					end
					if (seen.fast_clock !== want.fast_clock) begin
						$error("fast_clock expected %0h got %0h", want.fast_clock,
							seen.fast_clock);
						err_cnt++;
					end
					if (seen.read_valid !== want.read_valid) begin
						$error("read_valid expected %0h got %0h", want.read_valid,
							seen.read_valid);
						err_cnt++;
					end
					if (seen.read_byte !== want.read_byte) begin
						$error("read_byte expected %0h got %0h", want.read_byte, seen.read_byte);
						err_cnt++;
					end
					if (seen.data_request !== want.data_request) begin
						$error("data_request expected %0h got %0h", want.data_request,
							seen.data_request);
						err_cnt++;
					end
					if (seen.done_res !== want.done_res) begin
						$error("done_res expected %0h got %0h", want.done_res, seen.done_res);
						err_cnt++;
					end
					if (seen.status !== want.status) begin
						$error("status expected %0h got %0h", want.status, seen.status);
						err_cnt++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (predict(opcode, card_present, sector, block_count, rx_byte, data_byte))
					expq.push_back(nxt);
			end
			pending <= expq.size();
			cur_phase <= ph;
			cur_cmd <= cmd;
			cur_idx <= bidx;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import sdspi_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  opcode;
	logic        card_present;
	logic [22:0] sector;
	logic [7:0]  block_count;
	logic [7:0]  rx_byte;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        select_low;
	logic        fast_clock;
	logic        read_valid;
	logic [7:0]  read_byte;
	logic        data_request;
	logic        done_res;
	logic [2:0]  status;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	int          errors;
	int          pending;
	phase_t      cur_phase;
	logic [5:0]  cur_cmd;
	logic [9:0]  cur_idx;

	// our own copy of the block-count limit, to aim requests just past it
	logic [7:0]  lim_blocks;

	sd_card_spi_host_sequencer_unit uut (.*);

	sdspi_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// everything starts at a known level, with reset asserted at first
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_XDONE;
		card_present = 1'b0;
		sector = '0;
		block_count = '0;
		rx_byte = '0;
		data_byte = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TRIES;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// hard ceiling on run length
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// present one request and hold it until the block takes it
	task automatic offer(logic [2:0] op, logic cp, logic [22:0] sec, logic [7:0] cnt,
			logic [7:0] rx, logic [7:0] wd);
		in_valid <= 1'b1;
		opcode <= op;
		card_present <= cp;
		sector <= sec;
		block_count <= cnt;
		rx_byte <= rx;
		data_byte <= wd;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic rest(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// pick a sector, leaning towards the two ends of the range
	function automatic logic [22:0] pick_sector();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return 23'($urandom);
		endcase
	endfunction

	// pick a block count: mostly single or short multi-block, now and then
	// one past the limit so the parameter check fires
	function automatic logic [7:0] pick_count();
		case ($urandom_range(0, 9))
			0, 1: return 8'd0;
			2, 3, 4: return 8'd1;
			5, 6: return 8'd2;
			7: return 8'd3;
			default: begin
				if (lim_blocks != 8'hFF)
					return 8'($urandom_range(lim_blocks + 1, 255));
				return 8'($urandom_range(0, 1));
			end
		endcase
	endfunction

	// act as the card: choose the next request from what the sequencer is
	// waiting for; with noise allowed a fraction are random requests
	task automatic card_turn(bit noisy);
		logic [7:0] r;
		logic [7:0] hit;
		r = 8'($urandom);
		if (noisy && $urandom_range(0, 9) == 0) begin
			// noise: any opcode, any field, short or over-limit block counts
			offer(3'($urandom), 1'($urandom), 23'($urandom), pick_count(),
				8'($urandom), 8'($urandom));
			return;
		end
		case (cur_phase)
			PH_IDLE: begin
				if (!noisy) return;
				case ($urandom_range(0, 5))
					0, 1, 2: offer(OP_INIT, $urandom_range(0, 7) != 0, pick_sector(),
						pick_count(), r, 8'($urandom));
					3, 4: offer(OP_READ, 1'($urandom), pick_sector(), pick_count(), r,
						8'($urandom));
					default: offer(OP_WRITE, 1'($urandom), pick_sector(), pick_count(), r,
						8'($urandom));
				endcase
				return;
			end
			PH_WREQ: begin
				offer(OP_WDATA, 1'($urandom), 23'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom));
				return;
			end
			PH_RESP: begin
				hit = (cur_cmd == CMD_GO || cur_cmd == CMD_IFC) ? 8'h01 : 8'h00;
				if (cur_cmd == CMD_OPC)
					r = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'h01;
				else if ($urandom_range(0, 9) < 6)
					r = hit;
				else if ($urandom_range(0, 1) != 0)
					r = 8'hFF;
			end
			PH_RECV: begin
				// version-2 echo bytes, mostly right
				if (cur_idx == 2 && $urandom_range(0, 9) != 0) r = 8'h01;
				if (cur_idx == 3 && $urandom_range(0, 9) != 0) r = 8'hAA;
			end
			PH_TOKEN: if ($urandom_range(0, 2) == 0) r = 8'hFE;
			PH_WRESP: if ($urandom_range(0, 7) != 0) r = (r & 8'hE0) | 8'h05;
			PH_WBUSY, PH_BUSY: if ($urandom_range(0, 1) != 0) r = 8'h00;
			default: ;
		endcase
		offer(OP_XDONE, 1'($urandom), 23'($urandom), 8'($urandom), r, 8'($urandom));
	endtask

	// finish whatever sequence is open, let the results drain, then reprogram
	task automatic reprogram(logic [7:0] t, logic [7:0] w, logic [7:0] m);
		while (!(cur_phase == PH_IDLE && pending == 0)) begin
			if (cur_phase != PH_IDLE) begin
				card_turn(1'b0);
				rest(1);
			end else begin
				@(posedge clk);
			end
		end
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TRIES;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= CFG_WAKE;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_MAXB;
		cfg_data <= m;
		lim_blocks = m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one setting's worth of traffic, sent in bursts with gaps between them;
	// every well-formed request is followed by a rest with in_valid low, so the
	// checker's phase seen here already includes it
	task automatic traffic(int n);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && sent < n) begin
				card_turn(1'b1);
				rest(($urandom_range(0, 7) == 0) ? $urandom_range(2, 4) : 1);
				burst--;
				sent++;
			end
			if ($urandom_range(0, 2) == 0)
				rest($urandom_range(1, 20));
		end
	endtask

	// receiver: a pattern of its own, random stalls, clean stretches and long
	// hold-offs; the first long hold-off comes early so the block backs up
	initial begin
		int hold;
		@(posedge arst_n);
		repeat ($urandom_range(60, 120)) @(posedge clk);
		out_stall <= 1'b1;
		hold = 0;
		while (hold < 200) begin
			@(posedge clk);
			hold++;
		end
		forever begin
			case ($urandom_range(0, 11))
				0: begin
					out_stall <= 1'b1;
					repeat ($urandom_range(40, 150)) @(posedge clk);
				end
				1, 2: begin
					out_stall <= 1'b0;
					repeat ($urandom_range(30, 80)) @(posedge clk);
				end
				default: begin
					repeat ($urandom_range(10, 30)) begin
						out_stall <= ($urandom_range(0, 2) == 0);
						@(posedge clk);
					end
				end
			endcase
		end
	end

	// stimulus and verdict
	initial begin
		lim_blocks = 8'd128;
		@(posedge arst_n);
		@(posedge clk);

		// directed: items that must be ignored while idle
		offer(OP_XDONE, 1'b1, '0, '0, 8'h01, 8'h00);
		rest(1);
		offer(OP_WDATA, 1'b1, '0, '0, 8'h00, 8'hFF);
		rest(1);
		offer(3'd5, 1'b1, '1, '1, 8'hFF, 8'hFF);
		offer(3'd6, 1'b0, '0, '0, 8'h00, 8'h00);
		offer(3'd7, 1'b1, '1, '1, 8'hFF, 8'hFF);
		rest(1);
		// no card at init, then counts past the limit for read and write
		offer(OP_INIT, 1'b0, '0, '0, 8'h00, 8'h00);
		rest(1);
		offer(OP_READ, 1'b1, '1, 8'd255, 8'h00, 8'h00);
		rest(1);
		offer(OP_WRITE, 1'b1, '0, 8'd129, 8'h00, 8'h00);
		rest(1);
		// single-block read at the top sector, with a request while busy
		offer(OP_READ, 1'b1, '1, 8'd0, 8'h00, 8'h00);
		rest(1);
		offer(OP_INIT, 1'b1, '0, '0, 8'h00, 8'h00);
		rest(1);
		// a plain init, then let the card model carry it on
		reprogram(8'd8, 8'd10, 8'd128);
		offer(OP_INIT, 1'b1, '0, '0, 8'h00, 8'h00);
		rest(1);

		traffic(350);
		// sender pauses here until every result is in, at each reprogramming
		reprogram(8'd1, 8'd1, 8'd1);
		traffic(250);
		reprogram(8'd255, 8'd255, 8'd255);
		traffic(250);
		// zero limits behave as one
		reprogram(8'd0, 8'd0, 8'd2);
		traffic(220);
		reprogram(8'($urandom_range(1, 255)), 8'($urandom_range(1, 40)),
			8'($urandom_range(1, 255)));
		traffic(220);
		reprogram(8'd8, 8'd10, 8'd128);
		traffic(210);

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
